/* hw/rtl/rdhr_pkg.sv */
// Shared types, constants and the pixel depth decode for the hidden-register port
// of the palette DAC. No dependencies; imported by ramdac_hidden_register_port.
package rdhr_pkg;

  typedef struct packed {
    logic       operation;
    logic [1:0] port_offset;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       claimed;
    logic [1:0] pixel_depth;
    logic       depth_update;
  } out_item_t;

  localparam logic       OP_READ  = 1'b0;
  localparam logic       OP_WRITE = 1'b1;
  localparam logic [1:0] PORT_PIXEL_MASK = 2'd0;

  localparam logic [2:0] STEP_IDLE   = 3'd0;
  localparam logic [2:0] STEP_CMD    = 3'd4;
  localparam logic [2:0] STEP_IDX_LO = 3'd5;
  localparam logic [2:0] STEP_IDX_HI = 3'd6;
  localparam logic [2:0] STEP_DATA   = 3'd7;

  localparam logic [2:0] NEXT_READ_PLAIN [8] = '{3'd1, 3'd2, 3'd3, 3'd4,
                                                 3'd0, 3'd0, 3'd0, 3'd0};
  localparam logic [2:0] NEXT_READ_EXT   [8] = '{3'd1, 3'd2, 3'd3, 3'd4,
                                                 3'd5, 3'd6, 3'd7, 3'd7};
  localparam logic [2:0] NEXT_WRITE      [8] = '{3'd0, 3'd0, 3'd0, 3'd0,
                                                 3'd0, 3'd6, 3'd7, 3'd7};

  localparam logic [15:0] IDX_ID0   = 16'd0;
  localparam logic [15:0] IDX_ID1   = 16'd1;
  localparam logic [15:0] IDX_DEPTH = 16'd3;
  localparam logic [15:0] IDX_ID7   = 16'd7;

  localparam logic [7:0] ID_BYTE0  = 8'h44;
  localparam logic [7:0] ID_BYTE1  = 8'h03;
  localparam logic [7:0] ID_BYTE7  = 8'h88;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  localparam logic [7:0] CMD_DEPTH_MASK = 8'hE8;
  localparam int         CMD_EXT_BIT    = 4;
  localparam int         CMD_REG_DEPTH  = 3;

  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_15 = 2'd1;
  localparam logic [1:0] DEPTH_16 = 2'd2;
  localparam logic [1:0] DEPTH_24 = 2'd3;

  function automatic logic [1:0] decode_depth(input logic [7:0] cmd, input logic [7:0] reg3);
    logic [1:0] depth;
    depth = DEPTH_8;
    if (cmd[CMD_REG_DEPTH]) begin
      case (reg3) inside
        8'd1, 8'd2, 8'd8: depth = DEPTH_15;
        8'd3, 8'd6:       depth = DEPTH_16;
        8'd4, 8'd9:       depth = DEPTH_24;
        default:          depth = DEPTH_8;
      endcase
    end else begin
      case (cmd[7:5])
        3'd5:    depth = DEPTH_15;
        3'd6:    depth = DEPTH_16;
        3'd7:    depth = DEPTH_24;
        default: depth = DEPTH_8;
      endcase
    end
    return depth;
  endfunction

endpackage

/* hw/rtl/ramdac_hidden_register_port.sv */
// Hidden-register front end of a true-colour palette DAC on the pixel-mask port.
// Depends on rdhr_pkg for the request and result types, step codes and depth decode.
//
// Usage: each bus access is a request on the in_ channel (operation, port offset,
// write byte); each produces exactly one result on the out_ channel carrying the
// read byte, the claim flag, the decoded pixel depth and the depth-update flag.
// Unclaimed accesses are meant to be forwarded to the base VGA.
// Each accepted request is registered into the execute stage, and its result into
// the output register when it leaves; no new request is taken while one is in the
// execute stage. The register file is a synchronous memory: it is read at the
// accept edge and the request is finished and written back as it leaves execute.
// Reset (rst_n low, synchronous) clears the sequence step, command byte and index,
// and clears the per-entry valid bits at once, so the register file reads as zero
// with no clearing pass; the block accepts requests as soon as reset is released.
// Stall: a stalled result stays in the output register. One more request may be
// accepted meanwhile; it waits in the execute stage until the output is taken.
module ramdac_hidden_register_port
  import rdhr_pkg::*;
#(
  parameter int REG_COUNT = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int          IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [15:0] REG_LIMIT = 16'(REG_COUNT);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic [7:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;

  logic        state_r, state_nxt;
  in_item_t    item_r;
  logic [2:0]  step_r, step_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [7:0]  reg3_r, reg3_nxt;
  logic [7:0]  rd_q_r;
  logic        rd_valid_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, result;

  logic             in_accept, exec_go, mem_we, in_store;
  logic [IDX_W-1:0] addr;
  logic [7:0]       store_byte;

  assign in_accept  = in_valid && !in_stall;
  assign in_stall   = (state_r == ST_EXEC);
  assign exec_go    = (state_r == ST_EXEC) && !(out_valid_r && out_stall);
  assign addr       = idx_r[IDX_W-1:0];
  assign in_store   = (idx_r < REG_LIMIT);
  assign store_byte = rd_valid_r ? rd_q_r : 8'h00;

  always_comb begin
    step_nxt = step_r;
    cmd_nxt  = cmd_r;
    idx_nxt  = idx_r;
    reg3_nxt = reg3_r;
    mem_we   = 1'b0;
    result   = '0;
    if (item_r.port_offset != PORT_PIXEL_MASK) begin
      step_nxt = STEP_IDLE;
    end else if (item_r.operation == OP_WRITE) begin
      case (step_r)
        STEP_CMD: begin
          cmd_nxt             = item_r.write_data;
          result.depth_update = |((cmd_r ^ item_r.write_data) & CMD_DEPTH_MASK);
        end
        STEP_IDX_LO: idx_nxt = {idx_r[15:8], item_r.write_data};
        STEP_IDX_HI: idx_nxt = {item_r.write_data, idx_r[7:0]};
        STEP_DATA: begin
          mem_we = in_store;
          if (idx_r == IDX_DEPTH) begin
            reg3_nxt = item_r.write_data;
          end
          result.depth_update = (idx_r == IDX_DEPTH) && cmd_r[CMD_REG_DEPTH];
          idx_nxt = idx_r + 16'd1;
        end
        default: ;
      endcase
      result.claimed = step_r[2];
      step_nxt       = NEXT_WRITE[step_r];
    end else begin
      result.claimed = 1'b1;
      case (step_r)
        STEP_CMD:    result.read_data = cmd_r;
        STEP_IDX_LO: result.read_data = idx_r[7:0];
        STEP_IDX_HI: result.read_data = idx_r[15:8];
        STEP_DATA: begin
          if (idx_r == IDX_ID0) begin
            result.read_data = ID_BYTE0;
          end else if (idx_r == IDX_ID1) begin
            result.read_data = ID_BYTE1;
          end else if (idx_r == IDX_ID7) begin
            result.read_data = ID_BYTE7;
          end else if (in_store) begin
            result.read_data = store_byte;
          end else begin
            result.read_data = BYTE_ONES;
          end
          idx_nxt = idx_r + 16'd1;
        end
        default: result.read_data = BYTE_ONES;
      endcase
      step_nxt = cmd_r[CMD_EXT_BIT] ? NEXT_READ_EXT[step_r] : NEXT_READ_PLAIN[step_r];
    end
    result.pixel_depth = decode_depth(cmd_nxt, reg3_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    if (in_accept) begin
      state_nxt = ST_EXEC;
    end else if (exec_go) begin
      state_nxt = ST_IDLE;
    end
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= STEP_IDLE;
      cmd_r       <= 8'h00;
      idx_r       <= 16'h0000;
      reg3_r      <= 8'h00;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        step_r <= step_nxt;
        cmd_r  <= cmd_nxt;
        idx_r  <= idx_nxt;
        reg3_r <= reg3_nxt;
        if (mem_we) begin
          valid_r[addr] <= 1'b1;
        end
      end
    end
  end

  // Payload registers and the register file itself carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r     <= in_data;
      rd_q_r     <= mem[addr];
      rd_valid_r <= valid_r[addr];
    end
    if (exec_go) begin
      out_data_r <= result;
      if (mem_we) begin
        mem[addr] <= item_r.write_data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_enters_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_EXEC))
    else $error("accepted request did not enter the execute stage");

  a_exec_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("execute stage did not hand its result to the output");

  a_rose_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result appeared without an executed request");

  a_unclaimed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.claimed) |-> (out_data_r.read_data == 8'h00))
    else $error("unclaimed access returned nonzero read data");

  a_reg3_shadow: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[3] |-> (reg3_r == 8'h00))
    else $error("depth register shadow changed without a store write");

endmodule
